FILE: design/cwa_pkg.sv
// ============================================================================
// cwa_pkg - shared constants for the centered window average block
// Default sizes and the width of the radius register, used by the stream
// interfaces and by the top level.
// ============================================================================
package cwa_pkg;

    // Default largest window half width.
    localparam int MAX_RADIUS_DEF = 31;

    // Default width of one sample word.
    localparam int SAMPLE_BITS_DEF = 16;

    // Width of the radius configuration register.
    localparam int RADIUS_BITS = 5;

endpackage

FILE: design/cwa_if.sv
// ============================================================================
// cwa_if - stream channels of the centered window average block
// The sample channel carries one sample and its end-of-stream mark, and the
// result channel carries one average with its flags. Both use valid/ready.
// ============================================================================

// Sample channel: one word per accepted handshake.
interface cwa_in_if #(
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;

    modport source (
        output valid,
        output sample,
        output end_of_stream,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample,
        input  end_of_stream,
        output ready
    );
endinterface

// Result channel: one word per accepted handshake.
interface cwa_out_if #(
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          has_average;
    logic                          last_result;

    modport source (
        output valid,
        output average,
        output has_average,
        output last_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  average,
        input  has_average,
        input  last_result,
        output ready
    );
endinterface

FILE: design/centered_window_average.sv
// ============================================================================
// centered_window_average - centered moving average of radius k
// Keeps a ring of the last 2k+1 samples and their running sum, and divides
// the sum by 2k+1 with a shared radix-2 restoring divider.
// ============================================================================
//
//  Channel        Dir   Handshake      Word
//  -------------  ----  -------------  --------------------------------------
//  sample_stream  in    valid/ready    sample, end_of_stream
//  result_stream  out   valid/ready    average, has_average, last_result
//  cfg_wr_en      in    write strobe   cfg_wr_data = radius k
//
//  A sample that yields a full-window average goes from acceptance through
//  S_UPDATE, S_DIV and S_SEND before the block is ready again; the divider
//  does one quotient bit per cycle. A sample with no result passes through
//  S_UPDATE only; one that yields no average skips S_DIV. Each flushed result
//  after the last sample adds one word. A stalled result holds the block.
//  Reset clears the running sum, the ring pointer, the fill count and the
//  radius; the sample ring itself is not cleared.
//
module centered_window_average #(
    parameter int MAX_RADIUS  = cwa_pkg::MAX_RADIUS_DEF,
    parameter int SAMPLE_BITS = cwa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cwa_pkg::RADIUS_BITS-1:0] cfg_wr_data,
    cwa_in_if.sink                          sample_stream,
    cwa_out_if.source                       result_stream
);
    import cwa_pkg::*;

    localparam int K_BITS     = $clog2(MAX_RADIUS + 1);
    localparam int W_BITS     = K_BITS + 1;
    localparam int LINE_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
    localparam int TOTAL_BITS = SAMPLE_BITS + W_BITS;
    localparam int CNT_BITS   = $clog2(TOTAL_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_SEND
    } state_t;

    state_t                         state_reg;
    logic signed [TOTAL_BITS-1:0]   total_reg;
    logic [ADDR_BITS-1:0]           slot_reg;
    logic [W_BITS-1:0]              seen_reg;
    logic [RADIUS_BITS-1:0]         radius_reg;
    logic [K_BITS-1:0]              flush_reg;
    logic [CNT_BITS-1:0]            div_cnt_reg;

    logic signed [SAMPLE_BITS-1:0]  sample_reg;
    logic                           eos_reg;
    logic signed [SAMPLE_BITS-1:0]  rd_data_reg;
    logic [TOTAL_BITS-1:0]          dvd_reg;
    logic [W_BITS-1:0]              rem_reg;
    logic                           neg_reg;
    logic signed [SAMPLE_BITS-1:0]  avg_reg;
    logic                           has_reg;
    logic                           last_reg;

    logic signed [SAMPLE_BITS-1:0]  line_mem [LINE_DEPTH];

    logic                           in_accept;
    logic                           out_accept;
    logic [K_BITS-1:0]              k_val;
    logic [W_BITS-1:0]              w_val;
    logic                           window_wrapped;
    logic signed [TOTAL_BITS-1:0]   total_next;
    logic [TOTAL_BITS-1:0]          mag_next;
    logic [W_BITS-1:0]              slot_inc;
    logic [ADDR_BITS-1:0]           slot_next;
    logic [W_BITS-1:0]              seen_next;
    logic                           full_next;
    logic                           has_result;
    logic [W_BITS:0]                div_shifted;
    logic                           div_ge;
    logic [W_BITS-1:0]              rem_next;
    logic [TOTAL_BITS-1:0]          dvd_next;
    logic [SAMPLE_BITS-1:0]         quot_mag;
    logic signed [SAMPLE_BITS-1:0]  avg_next;

    // Handshakes: one item in flight, the result register holds the block.
    assign in_accept           = sample_stream.valid && sample_stream.ready;
    assign out_accept          = result_stream.valid && result_stream.ready;
    assign sample_stream.ready = (state_reg == S_IDLE);
    assign result_stream.valid = (state_reg == S_SEND);

    assign result_stream.average     = avg_reg;
    assign result_stream.has_average = has_reg;
    assign result_stream.last_result = last_reg;

    // Effective radius saturates at the largest supported value.
    always_comb
    begin
        if (int'(radius_reg) > MAX_RADIUS)
        begin
            k_val = K_BITS'(MAX_RADIUS);
        end
        else
        begin
            k_val = K_BITS'(radius_reg);
        end
    end

    assign w_val = {k_val, 1'b1};

    // Window update: drop the oldest sample once the window is full.
    assign window_wrapped = (seen_reg >= w_val);
    assign total_next = total_reg
                      - (window_wrapped ? TOTAL_BITS'(rd_data_reg) : '0)
                      + TOTAL_BITS'(sample_reg);
    assign mag_next   = total_next[TOTAL_BITS-1] ? TOTAL_BITS'(-total_next)
                                                 : TOTAL_BITS'(total_next);

    // Ring pointer wraps at the window length.
    assign slot_inc  = W_BITS'(slot_reg) + W_BITS'(1);
    assign slot_next = (slot_inc >= w_val) ? '0 : ADDR_BITS'(slot_inc);

    // Fill count saturates at the window length.
    assign seen_next  = window_wrapped ? seen_reg : seen_reg + W_BITS'(1);
    assign full_next  = (seen_next == w_val);
    assign has_result = (seen_next > W_BITS'(k_val));

    // One restoring divider step: one quotient bit per cycle.
    assign div_shifted = {rem_reg, dvd_reg[TOTAL_BITS-1]};
    assign div_ge      = (div_shifted >= {1'b0, w_val});
    assign rem_next    = div_ge ? W_BITS'(div_shifted - {1'b0, w_val})
                                : div_shifted[W_BITS-1:0];
    assign dvd_next    = {dvd_reg[TOTAL_BITS-2:0], div_ge};
    assign quot_mag    = dvd_next[SAMPLE_BITS-1:0];
    assign avg_next    = neg_reg ? SAMPLE_BITS'(-quot_mag) : SAMPLE_BITS'(quot_mag);

    // Sequencer and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            slot_reg    <= '0;
            seen_reg    <= '0;
            radius_reg  <= '0;
            flush_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
                total_reg  <= '0;
                slot_reg   <= '0;
                seen_reg   <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    if (eos_reg)
                    begin
                        total_reg <= '0;
                        slot_reg  <= '0;
                        seen_reg  <= '0;
                    end
                    else
                    begin
                        total_reg <= total_next;
                        slot_reg  <= slot_next;
                        seen_reg  <= seen_next;
                    end
                    if (has_result)
                    begin
                        flush_reg <= eos_reg ? k_val : '0;
                        if (full_next)
                        begin
                            div_cnt_reg <= CNT_BITS'(TOTAL_BITS);
                            state_reg   <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_SEND;
                        end
                    end
                    else if (eos_reg)
                    begin
                        flush_reg <= K_BITS'(seen_next - W_BITS'(1));
                        state_reg <= S_SEND;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - CNT_BITS'(1);
                    if (div_cnt_reg == CNT_BITS'(1))
                    begin
                        state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (out_accept)
                    begin
                        if (flush_reg != '0)
                        begin
                            flush_reg <= flush_reg - K_BITS'(1);
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Sample ring: written once per item, read with a registered port.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_UPDATE)
        begin
            line_mem[slot_reg] <= sample_reg;
        end
        if (in_accept)
        begin
            rd_data_reg <= line_mem[slot_reg];
        end
    end

    // Input capture, divider registers and the result word.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample_stream.sample;
            eos_reg    <= sample_stream.end_of_stream;
        end
        case (state_reg)
            S_UPDATE:
            begin
                dvd_reg <= mag_next;
                rem_reg <= '0;
                neg_reg <= total_next[TOTAL_BITS-1];
                avg_reg <= '0;
                if (has_result)
                begin
                    has_reg  <= full_next;
                    last_reg <= eos_reg && (k_val == '0);
                end
                else
                begin
                    has_reg  <= 1'b0;
                    last_reg <= (seen_next == W_BITS'(1));
                end
            end
            S_DIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                if (div_cnt_reg == CNT_BITS'(1))
                begin
                    avg_reg <= avg_next;
                end
            end
            S_SEND:
            begin
                if (out_accept && (flush_reg != '0))
                begin
                    avg_reg  <= '0;
                    has_reg  <= 1'b0;
                    last_reg <= (flush_reg == K_BITS'(1));
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The block never offers a result while it takes a new sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stream.ready |-> !result_stream.valid)
    else $error("sample accepted while a result is pending");

    // The fill count never exceeds the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= w_val)
    else $error("fill count beyond window length");

    // A word without an average carries zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_stream.valid && !result_stream.has_average |-> result_stream.average == '0)
    else $error("non-zero average on a word without average");

    // The last result of a stream leaves the block idle with a fresh stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && result_stream.last_result |=> sample_stream.ready && seen_reg == '0)
    else $error("stream not restarted after its last result");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for centered_window_average
// Streams of signed samples go in over the sample channel and every result
// word is compared against a behavioral model of the centered moving average
// or a hand-written result. The model has its own sample ring, running sum and
// fill count. The bench runs a directed table first and then random streams
// under several radius settings and patterns of idle cycles and result stalls.
// ============================================================================
module testbench;

    import cwa_pkg::*;

    localparam int SW            = SAMPLE_BITS_DEF;
    localparam int RB            = RADIUS_BITS;
    localparam int MAX_R         = MAX_RADIUS_DEF;
    localparam int RING_DEPTH    = 2 * MAX_R + 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 60;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [SW-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SW-1:0] S_MIN = 16'sh8000;

    // One result word as the block presents it.
    typedef struct packed {
        logic signed [SW-1:0] average;
        logic                 has_average;
        logic                 last_result;
    } window_result_t;

    // Directed table rows: a radius write, a sample checked against the
    // model, or a sample with its single result written out by hand.
    typedef enum logic [1:0] {
        ROW_RADIUS,
        ROW_SAMPLE,
        ROW_CHECKED
    } row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic signed [SW-1:0] value;
        logic                 eos;
        logic signed [SW-1:0] t_avg;
        logic                 t_has;
        logic                 t_last;
    } stim_row_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [RB-1:0]        cfg_wr_data;

    cwa_in_if  #(.SAMPLE_BITS(SW)) sample_if ();
    cwa_out_if #(.SAMPLE_BITS(SW)) result_if ();

    centered_window_average #(
        .MAX_RADIUS  (MAX_R),
        .SAMPLE_BITS (SW)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .sample_stream (sample_if),
        .result_stream (result_if)
    );

    // Model state of the moving average.
    logic signed [SW-1:0] win_ring [0:RING_DEPTH-1];
    logic signed [21:0]   win_total;
    logic [5:0]           win_slot;
    logic [6:0]           win_fill;
    logic [RB-1:0]        win_radius;

    window_result_t       step_results[$];
    window_result_t       expected_averages[$];
    window_result_t       oldest_average;

    stim_row_t            directed_rows [0:29];

    int                   send_pct;
    int                   recv_pct;
    int                   hold_request;
    int                   mismatches;
    int                   results_checked;
    int                   samples_sent;
    int                   streams_sent;
    int                   radius_writes;
    int                   long_holds;
    int                   cycle_count;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d with %0d results still outstanding.",
                     cycle_count, expected_averages.size());
            $display("** centered_window_average: FAILED **");
            $finish;
        end
    end

    // Clear the running sum, ring pointer and fill count.
    function automatic void restart_window();
        win_total = '0;
        win_slot  = '0;
        win_fill  = '0;
    endfunction

    // Advance the model by one sample and collect the result words it causes.
    function automatic void advance_window(input logic signed [SW-1:0] s, input logic eos);
        int                   k;
        int                   w;
        int                   slot;
        int                   flush;
        logic                 full;
        logic signed [SW-1:0] avg;
        longint               quot;
        k = int'(win_radius);
        w = 2 * k + 1;
        step_results.delete();

        // Replace the oldest sample once the window is full.
        slot = (win_slot < w) ? int'(win_slot) : 0;
        if (win_fill >= w)
            win_total = win_total - win_ring[slot];
        win_total      = win_total + s;
        win_ring[slot] = s;
        win_slot       = (slot + 1 >= w) ? 6'd0 : 6'(slot + 1);
        if (win_fill < w)
            win_fill = win_fill + 7'd1;

        // The result for the center sample, then any flushed tail.
        if (win_fill > k)
        begin
            full  = (win_fill == w);
            quot  = longint'(win_total) / longint'(w);
            avg   = full ? quot[SW-1:0] : '0;
            flush = eos ? k : 0;
            step_results.insert(step_results.size(),
                                window_result_t'{avg, full, eos && flush == 0});
            for (int j = 0; j < flush; j++)
                step_results.insert(step_results.size(),
                                    window_result_t'{'0, 1'b0, j + 1 == flush});
        end
        else if (eos)
        begin
            flush = int'(win_fill);
            for (int j = 0; j < flush; j++)
                step_results.insert(step_results.size(),
                                    window_result_t'{'0, 1'b0, j + 1 == flush});
        end

        if (eos)
            restart_window();
    endfunction

    // Offer one sample word, wait for it to be taken and record its results.
    task automatic send_sample(input logic signed [SW-1:0] s, input logic eos,
                               input bit typed, input window_result_t typed_res);
        while (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid         <= 1'b1;
        sample_if.sample        <= s;
        sample_if.end_of_stream <= eos;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);

        advance_window(s, eos);
        if (typed)
            expected_averages.insert(expected_averages.size(), typed_res);
        else
            foreach (step_results[i])
                expected_averages.insert(expected_averages.size(), step_results[i]);
        samples_sent++;
        if (eos)
            streams_sent++;
    endtask

    // Stop offering samples until every outstanding result has arrived.
    task automatic pause_sender();
        sample_if.valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
    endtask

    // Write the radius register once the block has gone quiet.
    task automatic set_radius(input logic [RB-1:0] r);
        pause_sender();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_radius = r;
        restart_window();
        radius_writes++;
    endtask

    // Result receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int held;
        result_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                held         = hold_request;
                hold_request = 0;
                result_if.ready <= 1'b0;
                repeat (held) @(posedge clk);
                long_holds++;
            end
            else
                result_if.ready <= !(recv_pct != 0 && $urandom_range(99) < recv_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_averages.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("Unexpected result word: avg %0d has %0b last %0b",
                             result_if.average, result_if.has_average,
                             result_if.last_result);
                mismatches++;
            end
            else
            begin
                oldest_average = expected_averages.pop_front();
                if (result_if.average !== oldest_average.average ||
                    result_if.has_average !== oldest_average.has_average ||
                    result_if.last_result !== oldest_average.last_result)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("Word %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 results_checked, oldest_average.average,
                                 oldest_average.has_average, oldest_average.last_result,
                                 result_if.average, result_if.has_average,
                                 result_if.last_result);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int             phase_radius [6];
        int             budget;
        int             sent;
        int             r;
        int             w;
        int             len;
        int             pick;
        bit             broken;
        bit             paused;
        logic signed [SW-1:0] s;
        window_result_t no_result;

        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= '0;
        sample_if.valid         <= 1'b0;
        sample_if.sample        <= '0;
        sample_if.end_of_stream <= 1'b0;
        send_pct     = 0;
        recv_pct     = 0;
        hold_request = 0;
        paused       = 1'b0;
        no_result    = '0;
        win_radius   = '0;
        restart_window();
        foreach (win_ring[i])
            win_ring[i] = '0;

        // Directed table. Hand-written results cover the radius after reset,
        // the sample extremes, a partial window and truncation toward zero.
        directed_rows = '{
            '{ROW_CHECKED, S_MAX,     1'b0, S_MAX,  1'b1, 1'b0},
            '{ROW_CHECKED, S_MIN,     1'b1, S_MIN,  1'b1, 1'b1},
            '{ROW_CHECKED, 16'sd0,    1'b1, 16'sd0, 1'b1, 1'b1},
            '{ROW_RADIUS,  16'sd1,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  S_MIN,     1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_CHECKED, S_MIN,     1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_CHECKED, S_MIN,     1'b0, S_MIN,  1'b1, 1'b0},
            '{ROW_SAMPLE,  S_MAX,     1'b1, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd1,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd1,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_CHECKED, -16'sd4,   1'b0, 16'sd0, 1'b1, 1'b0},
            '{ROW_SAMPLE,  S_MAX,     1'b1, 16'sd0, 1'b0, 1'b0},
            '{ROW_RADIUS,  16'sd3,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd5,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  -16'sd5,   1'b1, 16'sd0, 1'b0, 1'b0},
            '{ROW_CHECKED, 16'sd9,    1'b1, 16'sd0, 1'b0, 1'b1},
            '{ROW_RADIUS,  16'sd2,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd10,   1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd20,   1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd30,   1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_RADIUS,  16'sd2,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd1,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd2,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd3,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd4,    1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  16'sd5,    1'b1, 16'sd0, 1'b0, 1'b0},
            '{ROW_RADIUS,  16'sd31,   1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  S_MAX,     1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  -16'sd1,   1'b0, 16'sd0, 1'b0, 1'b0},
            '{ROW_SAMPLE,  S_MIN,     1'b1, 16'sd0, 1'b0, 1'b0}
        };

        // Reset once.
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table with no idling on either side.
        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_RADIUS:
                    set_radius(directed_rows[i].value[RB-1:0]);
                ROW_SAMPLE:
                    send_sample(directed_rows[i].value, directed_rows[i].eos, 1'b0, no_result);
                default:
                    send_sample(directed_rows[i].value, directed_rows[i].eos, 1'b1,
                                '{directed_rows[i].t_avg, directed_rows[i].t_has,
                                  directed_rows[i].t_last});
            endcase
        end

        // Random phases, each with its own radius and idle pattern.
        phase_radius = '{0, MAX_R, 1, $urandom_range(2, 3), 2, $urandom_range(2, 3)};
        for (int p = 0; p < 6; p++)
        begin
            set_radius(phase_radius[p][RB-1:0]);
            case (idle_mode_e'(p % 4))
                IDLE_NONE:     begin send_pct = 0;  recv_pct = 0;  end
                IDLE_SENDER:   begin send_pct = 55; recv_pct = 0;  end
                IDLE_RECEIVER: begin send_pct = 0;  recv_pct = 55; end
                default:       begin send_pct = 18; recv_pct = 18; end
            endcase

            // Hold results off while samples keep coming, so the block backs up.
            if (idle_mode_e'(p % 4) == IDLE_RECEIVER)
                hold_request = LONG_HOLD;

            r      = phase_radius[p];
            w      = 2 * r + 1;
            budget = (r == MAX_R) ? w : 4;
            sent   = 0;
            while (sent < budget)
            begin
                // Mostly full-window streams, some short ones, a few cut off
                // by a radius rewrite.
                pick = $urandom_range(9);
                if (r == MAX_R)
                    len = w;
                else if (pick < 7)
                    len = $urandom_range(w, w + 2);
                else
                    len = $urandom_range(1, w);
                broken = (pick == 9) && (r != MAX_R);

                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(7))
                        0:       s = S_MAX;
                        1:       s = S_MIN;
                        default: s = SW'($urandom);
                    endcase
                    send_sample(s, (i == len - 1) && !broken, 1'b0, no_result);

                    // Once, let the block drain completely in mid-stream.
                    if (idle_mode_e'(p % 4) == IDLE_BOTH && !paused && i == len / 2)
                    begin
                        pause_sender();
                        paused = 1'b1;
                    end
                end
                if (broken)
                    set_radius(r[RB-1:0]);
                sent += len;
            end
        end

        // Drain and let the block settle before the verdict.
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += expected_averages.size();

        $display("Ran %0d samples in %0d streams, %0d radius writes, %0d long stalls;",
                 samples_sent, streams_sent, radius_writes, long_holds);
        $display("%0d result words were compared and %0d did not match.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("** centered_window_average: PASSED **");
        else
            $display("** centered_window_average: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
design/cwa_pkg.sv
design/cwa_if.sv
design/centered_window_average.sv
tb/testbench.sv
